/* rtl/acse_pkg.sv */
// shared types and constants of the arccotangent series evaluator
`default_nettype none

package acse_pkg;

   // fixed-point formats
   localparam int FRAC_W  = 30;
   localparam int X_W     = 32;
   localparam int MAG_W   = 30;
   localparam int PROD_W  = 60;
   localparam int SUM_W   = 34;
   localparam int TERMS_W = 13;
   localparam int STS_W   = 2;

   // round(pi/2 * 2^30) and the clamp limit, just under 3.0, of the unsigned Q2.30 result
   localparam logic signed [SUM_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [SUM_W-1:0] SUM_MAX     = 34'sd3221225471;
   localparam logic [PROD_W:0]         ROUND_HALF  = 61'd536870912;

   // result status codes
   localparam logic [STS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STS_W-1:0] STATUS_DOMAIN = 2'd1;
   localparam logic [STS_W-1:0] STATUS_LIMIT  = 2'd2;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQUARE,
      OP_INIT,
      OP_MULX,
      OP_ROUND,
      OP_MULN,
      OP_DIVSTART,
      OP_ACC,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [STS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic domain_err;
      logic div_busy;
      logic below_tol;
      logic at_limit;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/acse_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module acse_div #(
   parameter int DVD_W = 44,
   parameter int DVS_W = 14
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  busy,
   output logic [DVD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   // trial subtraction of the divisor from the shifted remainder
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and result registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   // the divider keeps running until its last quotient bit
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && cnt_ff != CNT_W'(1) |=> busy_ff)
      else $error("divider stopped early");
`endif

endmodule

`default_nettype wire

/* rtl/acse_dp.sv */
// datapath: term magnitude, square of x, shared multiplier, sum and result registers
`default_nettype none

module acse_dp #(
   parameter int MAX_TERMS = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire acse_pkg::cmd_type                 cmd,
   input  wire logic [acse_pkg::MAG_W-1:0]        tolerance,
   input  wire logic signed [acse_pkg::X_W-1:0]   req_x_value,
   output acse_pkg::sts_type                      sts,
   output logic [acse_pkg::X_W-1:0]               rsp_series_sum,
   output logic [acse_pkg::TERMS_W-1:0]           rsp_terms_used,
   output logic [acse_pkg::STS_W-1:0]             rsp_status
);

   localparam int N_W = $clog2(MAX_TERMS + 1);
   localparam int P_W = acse_pkg::MAG_W + N_W + 1;

   logic [acse_pkg::X_W-1:0]            x_ff, x_in;
   logic [acse_pkg::MAG_W-1:0]          mag_ff, mag_in;
   logic [acse_pkg::MAG_W-1:0]          x2_ff, x2_in;
   logic [acse_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic [N_W-1:0]                      n_ff, n_in;
   logic                                aneg_ff, aneg_in;
   logic signed [acse_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [acse_pkg::X_W-1:0]            ssum_ff, ssum_in;
   logic [acse_pkg::TERMS_W-1:0]        terms_ff, terms_in;
   logic [acse_pkg::STS_W-1:0]          stat_ff, stat_in;

   logic [acse_pkg::X_W-1:0]            mx;
   logic [acse_pkg::MAG_W-1:0]          mul_a, mul_b;
   logic [acse_pkg::PROD_W-1:0]         mul_p;
   logic [acse_pkg::PROD_W:0]           rnd_sum;
   logic [acse_pkg::MAG_W-1:0]          rnd;
   logic [N_W:0]                        num, den;
   logic [P_W-1:0]                      dividend;
   logic [P_W-1:0]                      quotient;
   logic                                div_busy;
   logic [acse_pkg::MAG_W-1:0]          quo;
   logic signed [acse_pkg::SUM_W-1:0]   mx_s, quo_s, sum_next, sat_sum;
   logic [31:0]                         n_ext;

   // magnitude of the argument
   assign mx   = x_ff[acse_pkg::X_W-1] ? (32'd0 - x_ff) : x_ff;
   assign mx_s = signed'(acse_pkg::SUM_W'(mx[acse_pkg::MAG_W-1:0]));

   // recurrence factors (2n-1) and (2n+1)
   assign num = {n_ff, 1'b0} - (N_W+1)'(1);
   assign den = {n_ff, 1'b1};

   // shared multiplier operand select
   always_comb begin
      case (cmd.op)
         acse_pkg::OP_SQUARE: begin
            mul_a = mx[acse_pkg::MAG_W-1:0];
            mul_b = mx[acse_pkg::MAG_W-1:0];
         end
         acse_pkg::OP_MULX: begin
            mul_a = mag_ff;
            mul_b = x2_ff;
         end
         default: begin
            mul_a = mag_ff;
            mul_b = acse_pkg::MAG_W'(num);
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // round half up from Q0.60 to Q0.30
   assign rnd_sum = {1'b0, prod_ff} + acse_pkg::ROUND_HALF;
   assign rnd     = rnd_sum[acse_pkg::PROD_W-1:acse_pkg::FRAC_W];

   // dividend with half the divisor added for rounding
   assign dividend = prod_ff[P_W-1:0] + P_W'(n_ff);

   acse_div #(
      .DVD_W (P_W),
      .DVS_W (N_W + 1)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == acse_pkg::OP_DIVSTART),
      .dividend (dividend),
      .divisor  (den),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign quo      = quotient[acse_pkg::MAG_W-1:0];
   assign quo_s    = signed'(acse_pkg::SUM_W'(quo));
   assign sum_next = aneg_ff ? (sum_ff + quo_s) : (sum_ff - quo_s);

   // clamp the sum into the unsigned Q2.30 range
   always_comb begin
      if (sum_ff < 0) begin
         sat_sum = '0;
      end else if (sum_ff > acse_pkg::SUM_MAX) begin
         sat_sum = acse_pkg::SUM_MAX;
      end else begin
         sat_sum = sum_ff;
      end
   end

   assign n_ext = 32'(n_ff);

   // register updates per operation
   always_comb begin
      x_in     = x_ff;
      mag_in   = mag_ff;
      x2_in    = x2_ff;
      prod_in  = prod_ff;
      n_in     = n_ff;
      aneg_in  = aneg_ff;
      sum_in   = sum_ff;
      ssum_in  = ssum_ff;
      terms_in = terms_ff;
      stat_in  = stat_ff;
      case (cmd.op)
         acse_pkg::OP_LOAD: begin
            x_in = req_x_value;
            n_in = '0;
         end
         acse_pkg::OP_SQUARE: begin
            prod_in = mul_p;
            mag_in  = mx[acse_pkg::MAG_W-1:0];
         end
         acse_pkg::OP_INIT: begin
            x2_in   = rnd;
            aneg_in = !x_ff[acse_pkg::X_W-1];
            sum_in  = x_ff[acse_pkg::X_W-1] ? (acse_pkg::HALF_PI_Q30 + mx_s)
                                            : (acse_pkg::HALF_PI_Q30 - mx_s);
         end
         acse_pkg::OP_MULX: begin
            prod_in = mul_p;
            n_in    = n_ff + 1'b1;
         end
         acse_pkg::OP_ROUND: begin
            mag_in = rnd;
         end
         acse_pkg::OP_MULN: begin
            prod_in = mul_p;
         end
         acse_pkg::OP_ACC: begin
            mag_in  = quo;
            aneg_in = !aneg_ff;
            sum_in  = sum_next;
         end
         acse_pkg::OP_FINISH: begin
            stat_in = cmd.status;
            if (cmd.status == acse_pkg::STATUS_DOMAIN) begin
               ssum_in  = '0;
               terms_in = '0;
            end else begin
               ssum_in  = sat_sum[acse_pkg::X_W-1:0];
               terms_in = n_ext[acse_pkg::TERMS_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      mag_ff   <= mag_in;
      x2_ff    <= x2_in;
      prod_ff  <= prod_in;
      n_ff     <= n_in;
      aneg_ff  <= aneg_in;
      sum_ff   <= sum_in;
      ssum_ff  <= ssum_in;
      terms_ff <= terms_in;
      stat_ff  <= stat_in;
   end

   // status to the controller
   assign sts.domain_err = (mx[acse_pkg::X_W-1:acse_pkg::MAG_W] != 2'b00);
   assign sts.div_busy   = div_busy;
   assign sts.below_tol  = (mag_ff < tolerance);
   assign sts.at_limit   = (n_ff == N_W'(MAX_TERMS));

   assign rsp_series_sum = ssum_ff;
   assign rsp_terms_used = terms_ff;
   assign rsp_status     = stat_ff;

endmodule

`default_nettype wire

/* rtl/acse_ctrl.sv */
// controller: sequences the series loop and owns the result handshake
`default_nettype none

module acse_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire acse_pkg::sts_type  sts,
   output acse_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQUARE,
      S_INIT,
      S_MULX,
      S_ROUND,
      S_MULN,
      S_DIVSTART,
      S_DIVWAIT,
      S_CHECK,
      S_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [acse_pkg::STS_W-1:0]  fin_ff, fin_in;
   logic                        slot_free;
   logic                        finish;

   // the result register can take a new result
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == S_FINISH) && slot_free;

   // next state and datapath command
   always_comb begin
      state_in   = state_ff;
      fin_in     = fin_ff;
      cmd.op     = acse_pkg::OP_NONE;
      cmd.status = fin_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = acse_pkg::OP_LOAD;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (sts.domain_err) begin
               fin_in   = acse_pkg::STATUS_DOMAIN;
               state_in = S_FINISH;
            end else begin
               cmd.op   = acse_pkg::OP_SQUARE;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.op   = acse_pkg::OP_INIT;
            state_in = S_MULX;
         end
         S_MULX: begin
            cmd.op   = acse_pkg::OP_MULX;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op   = acse_pkg::OP_ROUND;
            state_in = S_MULN;
         end
         S_MULN: begin
            cmd.op   = acse_pkg::OP_MULN;
            state_in = S_DIVSTART;
         end
         S_DIVSTART: begin
            cmd.op   = acse_pkg::OP_DIVSTART;
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (!sts.div_busy) begin
               cmd.op   = acse_pkg::OP_ACC;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.below_tol) begin
               fin_in   = acse_pkg::STATUS_OK;
               state_in = S_FINISH;
            end else if (sts.at_limit) begin
               fin_in   = acse_pkg::STATUS_LIMIT;
               state_in = S_FINISH;
            end else begin
               state_in = S_MULX;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.op   = acse_pkg::OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= acse_pkg::STATUS_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // a result is loaded only into a free result register
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == acse_pkg::OP_FINISH |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten while pending");

   // terms are accumulated only once the quotient is complete
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == acse_pkg::OP_ACC |-> !sts.div_busy)
      else $error("accumulate while divider busy");

   // a new result appears only after a finish command
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == acse_pkg::OP_FINISH))
      else $error("result valid without finish");
`endif

endmodule

`default_nettype wire

/* rtl/arccot_series_evaluator.sv */
// top level: arccotangent series evaluator with tolerance register
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_x_value
//   rsp       out        rsp_valid/rsp_ready  rsp_series_sum, rsp_terms_used, rsp_status
//   csr       in/out     APB, pready high     tolerance at byte address 0
//
// each term is paced by the bit-serial divider that divides by 2n+1; an argument outside
// (-1,1) is answered with a domain status and no terms;
// one request at a time; the next is taken while a result waits in the output register
// synchronous active-high reset clears the controller, divider and tolerance (to 1074)
`default_nettype none

module arccot_series_evaluator #(
   parameter int MAX_TERMS = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [acse_pkg::X_W-1:0]   req_x_value,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [acse_pkg::X_W-1:0]               rsp_series_sum,
   output logic [acse_pkg::TERMS_W-1:0]           rsp_terms_used,
   output logic [acse_pkg::STS_W-1:0]             rsp_status,
   // configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [2:0]                        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   logic [acse_pkg::MAG_W-1:0] tol_ff, tol_in;
   logic                       csr_wr;
   acse_pkg::cmd_type          cmd;
   acse_pkg::sts_type          sts;

   // tolerance register write
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);

   always_comb begin
      tol_in = tol_ff;
      if (csr_wr) begin
         tol_in = csr_pwdata[acse_pkg::MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= acse_pkg::MAG_W'(1074);
      end else begin
         tol_ff <= tol_in;
      end
   end

   // register readback
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? 32'(tol_ff) : 32'd0;
   assign csr_pready = 1'b1;

   acse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   acse_dp #(
      .MAX_TERMS (MAX_TERMS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .tolerance      (tol_ff),
      .req_x_value    (req_x_value),
      .sts            (sts),
      .rsp_series_sum (rsp_series_sum),
      .rsp_terms_used (rsp_terms_used),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire
